### rtl/core/prm_pkg.sv
package prm_pkg;

  // fixed field widths
  localparam int ADDR_W    = 10;
  localparam int CNT_W     = 11;
  localparam int AMT_W     = 4;
  localparam int DATA_W    = 64;
  localparam int MODE_W    = 3;

  // cell store geometry
  localparam int MAX_CELLS    = 1024;
  localparam int CELL_BITS    = 8;
  localparam int ACCESS_LIMIT = 8;
  localparam int NUM_BANKS    = 8;
  localparam int BANK_W       = 3;
  localparam int ROWS         = MAX_CELLS / NUM_BANKS;
  localparam int ROW_W        = 7;
  localparam int LANE_W       = 4;

  localparam int RANGES_DEF   = 8;
  localparam logic [CNT_W-1:0] CELLS_RESET = CNT_W'(64);

  typedef enum logic [MODE_W-1:0] {
    OP_READ      = 3'd0,
    OP_WRITE     = 3'd1,
    OP_PROTECT   = 3'd2,
    OP_UNPROTECT = 3'd3,
    OP_UNPROT_ALL = 3'd4,
    OP_QUERY     = 3'd5,
    OP_CLEAR     = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } st_t;

  // command to the range table, commit marks the cycle the result is taken
  typedef struct packed {
    logic             commit;
    op_t              op;
    logic [CNT_W-1:0] lo;
    logic [CNT_W-1:0] hi;
  } rng_cmd_t;

  typedef struct packed {
    logic overlap;
    logic full;
  } rng_rsp_t;

endpackage

### rtl/core/prm_if.sv
interface prm_in_if;
  logic                       valid;
  logic                       ready;
  logic [prm_pkg::MODE_W-1:0] mode;
  logic [prm_pkg::ADDR_W-1:0] address;
  logic [prm_pkg::AMT_W-1:0]  amount;
  logic [prm_pkg::DATA_W-1:0] write_data;
  logic                       override_protection;

  modport source (output valid, mode, address, amount, write_data, override_protection,
                  input ready);
  modport sink (input valid, mode, address, amount, write_data, override_protection,
                output ready);
endinterface

interface prm_out_if;
  logic                       valid;
  logic                       ready;
  logic [prm_pkg::DATA_W-1:0] read_data;
  logic                       write_done;
  logic                       is_protected;
  logic                       table_full;
  logic [prm_pkg::ADDR_W-1:0] update_begin;
  logic [prm_pkg::CNT_W-1:0]  update_count;

  modport source (output valid, read_data, write_done, is_protected, table_full,
                  update_begin, update_count, input ready);
  modport sink (input valid, read_data, write_done, is_protected, table_full,
                update_begin, update_count, output ready);
endinterface

interface prm_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [prm_pkg::CNT_W-1:0] cells_in_use;

  modport source (output valid, cells_in_use, input ready);
  modport sink (input valid, cells_in_use, output ready);
endinterface

### rtl/core/protected_range_memory.sv
// Cell memory with range protection.
// in_word carries one request (read, write, protect, unprotect, unprotect all,
// query, clear memory); out_word returns exactly one result word per request.
// cfg_word sets cells_in_use and is always ready; write it only while idle.
// Cells sit in eight banks of 128 rows, one cell per bank per access, so any
// run of up to eight cells is one read and one write of each bank.
// Per item, the accept cycle issues the bank reads; the execute state merges
// read data, checks and updates the range table and writes back.
// in_word.ready is high in idle; the result sits in an output register, so the
// next word is taken while the previous result waits. If out_word stays
// stalled, the second item holds in its execute state until the register frees.
// Reset and clear memory sweep all 128 rows (one row per cycle, all banks),
// with in_word.ready low during the sweep; cells_in_use resets to 64.
module protected_range_memory #(
  parameter int MAX_RANGES = prm_pkg::RANGES_DEF
) (
  input logic        clk,
  input logic        rst_n,
  prm_in_if.sink     in_word,
  prm_out_if.source  out_word,
  prm_cfg_if.sink    cfg_word
);
  import prm_pkg::*;

  st_t                  state_r, state_nxt;
  logic [ROW_W-1:0]     clr_row_r, clr_row_nxt;
  logic [CNT_W-1:0]     cells_r;

  // captured request
  op_t                  mode_r;
  logic [ADDR_W-1:0]    addr_r;
  logic [LANE_W-1:0]    amt_r;
  logic [DATA_W-1:0]    data_r;
  logic                 ovr_r;

  // output register
  logic                 out_valid_r;
  logic [DATA_W-1:0]    rd_r;
  logic                 done_r, prot_r, full_r;
  logic [ADDR_W-1:0]    ubeg_r;
  logic [CNT_W-1:0]     ucnt_r;

  logic                 accept, commit, clearing, do_write;
  logic [LANE_W-1:0]    amt_sat, k;
  logic [CNT_W-1:0]     live, room;
  logic [DATA_W-1:0]    rd_data;

  logic [CELL_BITS-1:0] bank_q_r   [NUM_BANKS];
  logic [CELL_BITS-1:0] bank_wdata [NUM_BANKS];
  logic [ROW_W-1:0]     bank_raddr [NUM_BANKS];
  logic [ROW_W-1:0]     bank_waddr [NUM_BANKS];
  logic [NUM_BANKS-1:0] bank_we;

  rng_cmd_t             rcmd;
  rng_rsp_t             rrsp;

  assign accept = in_word.valid && in_word.ready;
  assign amt_sat = (in_word.amount > LANE_W'(ACCESS_LIMIT)) ? LANE_W'(ACCESS_LIMIT)
                                                            : in_word.amount;

  // effective cell count and clipped access length
  always_comb begin
    live = (cells_r > CNT_W'(MAX_CELLS)) ? CNT_W'(MAX_CELLS) : cells_r;
    room = live - {1'b0, addr_r};
    if ({1'b0, addr_r} >= live) k = '0;
    else if (room < {7'd0, amt_r}) k = room[LANE_W-1:0];
    else k = amt_r;
  end

  // range table
  assign rcmd.commit = commit;
  assign rcmd.op     = mode_r;
  assign rcmd.lo     = {1'b0, addr_r};
  assign rcmd.hi     = {1'b0, addr_r} + {7'd0, amt_r};

  prm_range_table #(.MAX_RANGES(MAX_RANGES)) u_ranges (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (rcmd),
    .rsp   (rrsp)
  );

  assign do_write = mode_r == OP_WRITE && (ovr_r || !rrsp.overlap) && k != '0;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_row_r == ROW_W'(ROWS - 1)) state_nxt = ST_IDLE;
      ST_IDLE:  if (accept) state_nxt = ST_EXEC;
      ST_EXEC:  if (commit) state_nxt = (mode_r == OP_CLEAR) ? ST_CLEAR : ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_word.ready = 1'b0;
    commit        = 1'b0;
    clearing      = 1'b0;
    clr_row_nxt   = '0;
    unique case (state_r)
      ST_CLEAR: begin
        clearing    = 1'b1;
        clr_row_nxt = clr_row_r + ROW_W'(1);
      end
      ST_IDLE:  in_word.ready = 1'b1;
      ST_EXEC:  commit = !out_valid_r || out_word.ready;
      default: ;
    endcase
  end

  assign cfg_word.ready = 1'b1;

  // bank addressing: bank b holds lane (b - addr) mod 8
  always_comb begin
    logic [BANK_W-1:0] roff, woff;
    logic [CNT_W-1:0]  rcell, wcell;
    for (int b = 0; b < NUM_BANKS; b++) begin
      roff  = BANK_W'(b) - in_word.address[BANK_W-1:0];
      rcell = {1'b0, in_word.address} + {8'd0, roff};
      woff  = BANK_W'(b) - addr_r[BANK_W-1:0];
      wcell = {1'b0, addr_r} + {8'd0, woff};
      bank_raddr[b] = rcell[BANK_W +: ROW_W];
      if (clearing) begin
        bank_waddr[b] = clr_row_r;
        bank_wdata[b] = '0;
        bank_we[b]    = 1'b1;
      end else begin
        bank_waddr[b] = wcell[BANK_W +: ROW_W];
        bank_wdata[b] = data_r[woff * CELL_BITS +: CELL_BITS];
        bank_we[b]    = commit && do_write && ({1'b0, woff} < k);
      end
    end
  end

  // read data assembly, lanes past the clip read zero
  always_comb begin
    logic [BANK_W-1:0] bsel;
    rd_data = '0;
    for (int i = 0; i < ACCESS_LIMIT; i++) begin
      bsel = addr_r[BANK_W-1:0] + BANK_W'(i);
      if (LANE_W'(i) < k) rd_data[i * CELL_BITS +: CELL_BITS] = bank_q_r[bsel];
    end
  end

  // cell banks
  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    logic [CELL_BITS-1:0] mem [ROWS];
    always_ff @(posedge clk) begin
      if (bank_we[b]) mem[bank_waddr[b]] <= bank_wdata[b];
      if (accept) bank_q_r[b] <= mem[bank_raddr[b]];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_row_r   <= '0;
      out_valid_r <= 1'b0;
      cells_r     <= CELLS_RESET;
    end else begin
      state_r   <= state_nxt;
      clr_row_r <= clr_row_nxt;
      if (commit) out_valid_r <= 1'b1;
      else if (out_word.ready) out_valid_r <= 1'b0;
      if (cfg_word.valid) cells_r <= cfg_word.cells_in_use;
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= op_t'(in_word.mode);
      addr_r <= in_word.address;
      amt_r  <= amt_sat;
      data_r <= in_word.write_data;
      ovr_r  <= in_word.override_protection;
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (commit) begin
      rd_r   <= (mode_r == OP_READ || mode_r == OP_WRITE) ? rd_data : '0;
      done_r <= do_write;
      prot_r <= (mode_r == OP_WRITE || mode_r == OP_QUERY) && rrsp.overlap;
      full_r <= rrsp.full;
      ubeg_r <= do_write ? addr_r : '0;
      if (do_write) ucnt_r <= {7'd0, k};
      else if (mode_r == OP_CLEAR) ucnt_r <= live;
      else ucnt_r <= '0;
    end
  end

  assign out_word.valid        = out_valid_r;
  assign out_word.read_data    = rd_r;
  assign out_word.write_done   = done_r;
  assign out_word.is_protected = prot_r;
  assign out_word.table_full   = full_r;
  assign out_word.update_begin = ubeg_r;
  assign out_word.update_count = ucnt_r;

`ifndef SYNTHESIS
  a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == ST_EXEC)
    else $error("accepted word did not enter execute");
  a_clear_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    commit && mode_r == OP_CLEAR |=> state_r == ST_CLEAR && clr_row_r == '0)
    else $error("clear memory did not start sweep at row zero");
  a_sweep_end: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CLEAR && clr_row_r == ROW_W'(ROWS - 1) |=> state_r == ST_IDLE)
    else $error("sweep did not end after last row");
  a_commit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> out_valid_r)
    else $error("committed result not presented");
`endif

endmodule

### rtl/core/prm_range_table.sv
module prm_range_table #(
  parameter int MAX_RANGES = prm_pkg::RANGES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  prm_pkg::rng_cmd_t cmd,
  output prm_pkg::rng_rsp_t rsp
);
  import prm_pkg::*;

  localparam int RIW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;

  logic [CNT_W-1:0]      beg_r [MAX_RANGES];
  logic [CNT_W-1:0]      end_r [MAX_RANGES];
  logic [CNT_W-1:0]      beg_nxt [MAX_RANGES];
  logic [CNT_W-1:0]      end_nxt [MAX_RANGES];
  logic [MAX_RANGES-1:0] valid_r, valid_nxt;

  logic [MAX_RANGES-1:0] touch, ovl, contain;
  logic [CNT_W-1:0]      mn_or, mx_or, split_end;
  logic                  has_mn, has_mx, has_touch, has_free, need_split, amt_nz;
  logic [RIW-1:0]        first_idx, free_idx;

  // per-entry compares; ranges are disjoint and never adjacent, so at most one
  // touched entry extends past each end and an OR-select picks it
  always_comb begin
    mn_or = '0;
    mx_or = '0;
    split_end = '0;
    has_mn = 1'b0;
    has_mx = 1'b0;
    has_touch = 1'b0;
    has_free = 1'b0;
    first_idx = '0;
    free_idx = '0;
    for (int i = 0; i < MAX_RANGES; i++) begin
      touch[i]   = valid_r[i] && beg_r[i] <= cmd.hi && end_r[i] >= cmd.lo;
      ovl[i]     = valid_r[i] && beg_r[i] <  cmd.hi && end_r[i] >  cmd.lo;
      contain[i] = valid_r[i] && beg_r[i] <  cmd.lo && end_r[i] >  cmd.hi;
      if (touch[i] && beg_r[i] < cmd.lo) begin
        mn_or  = mn_or | beg_r[i];
        has_mn = 1'b1;
      end
      if (touch[i] && end_r[i] > cmd.hi) begin
        mx_or  = mx_or | end_r[i];
        has_mx = 1'b1;
      end
      if (contain[i]) split_end = split_end | end_r[i];
    end
    // lowest touched entry and lowest free entry
    for (int i = MAX_RANGES - 1; i >= 0; i--) begin
      if (touch[i]) begin
        first_idx = RIW'(i);
        has_touch = 1'b1;
      end
      if (!valid_r[i]) begin
        free_idx = RIW'(i);
        has_free = 1'b1;
      end
    end
    need_split = |contain;
    amt_nz     = cmd.hi != cmd.lo;
  end

  // response
  always_comb begin
    rsp.overlap = |ovl;
    rsp.full    = 1'b0;
    if (amt_nz && cmd.op == OP_PROTECT && !has_touch && !has_free) rsp.full = 1'b1;
    if (amt_nz && cmd.op == OP_UNPROTECT && need_split && !has_free) rsp.full = 1'b1;
  end

  // table update
  always_comb begin
    valid_nxt = valid_r;
    for (int i = 0; i < MAX_RANGES; i++) begin
      beg_nxt[i] = beg_r[i];
      end_nxt[i] = end_r[i];
    end
    if (cmd.commit) begin
      unique case (cmd.op)
        OP_PROTECT: begin
          if (amt_nz && has_touch) begin
            for (int i = 0; i < MAX_RANGES; i++) begin
              if (touch[i] && RIW'(i) != first_idx) valid_nxt[i] = 1'b0;
            end
            beg_nxt[first_idx]   = has_mn ? mn_or : cmd.lo;
            end_nxt[first_idx]   = has_mx ? mx_or : cmd.hi;
            valid_nxt[first_idx] = 1'b1;
          end else if (amt_nz && has_free) begin
            beg_nxt[free_idx]   = cmd.lo;
            end_nxt[free_idx]   = cmd.hi;
            valid_nxt[free_idx] = 1'b1;
          end
        end
        OP_UNPROTECT: begin
          if (amt_nz && !(need_split && !has_free)) begin
            for (int i = 0; i < MAX_RANGES; i++) begin
              if (ovl[i]) begin
                if (beg_r[i] < cmd.lo) end_nxt[i] = cmd.lo;
                else if (end_r[i] > cmd.hi) beg_nxt[i] = cmd.hi;
                else valid_nxt[i] = 1'b0;
              end
            end
            // right remainder of a range cut in the middle
            if (need_split) begin
              beg_nxt[free_idx]   = cmd.hi;
              end_nxt[free_idx]   = split_end;
              valid_nxt[free_idx] = 1'b1;
            end
          end
        end
        OP_UNPROT_ALL: valid_nxt = '0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RANGES; i++) begin
      beg_r[i] <= beg_nxt[i];
      end_r[i] <= end_nxt[i];
    end
  end

`ifndef SYNTHESIS
  a_full_only_when_packed: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.full |-> &valid_r)
    else $error("table full reported with a free entry");
  a_unprot_all_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && cmd.op == OP_UNPROT_ALL |=> valid_r == '0)
    else $error("entries left after unprotect all");
  a_protect_stores: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && cmd.op == OP_PROTECT && amt_nz && !rsp.full |=> valid_r != '0)
    else $error("protect left table empty");
`endif

endmodule
